// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the link quality meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on every rising clock edge, ignored while in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/swlq_pkg.sv =====
// ----------------------------------------------------------------------------
// swlq_pkg
// Widths, constants and ring entry types for the link quality meter.
// ----------------------------------------------------------------------------
package swlq_pkg;

  // Ring depths
  localparam int LOSS_DEPTH = 64;
  localparam int SEND_DEPTH = 64;
  localparam int LOSS_AW    = $clog2(LOSS_DEPTH);
  localparam int LOSS_CW    = $clog2(LOSS_DEPTH + 1);
  localparam int SEND_AW    = $clog2(SEND_DEPTH);
  localparam int SEND_CW    = $clog2(SEND_DEPTH + 1);

  // Field widths
  localparam int STAMP_W = 32;
  localparam int LOST_W  = 17;
  localparam int BYTES_W = 32;
  localparam int PING_W  = 16;
  localparam int RATE_W  = 48;
  localparam int REQ_W   = 2;

  // Running totals and the scaled byte sum
  localparam int LOSS_TOT_W  = LOST_W + LOSS_CW;
  localparam int BYTES_TOT_W = BYTES_W + SEND_CW;
  localparam int PING_TOT_W  = PING_W + SEND_CW;
  localparam int MS_W        = 10;
  localparam int PROD_W      = BYTES_TOT_W + MS_W;

  // Shared divider
  localparam int DIV_N_W = PROD_W;
  localparam int DIV_D_W = 32;
  localparam int DIV_CW  = $clog2(DIV_N_W + 1);

  // Constants
  localparam logic [LOST_W-1:0]  Q16_ONE      = LOST_W'(65536);
  localparam logic [MS_W-1:0]    MS_PER_S     = MS_W'(1000);
  localparam logic [STAMP_W-1:0] WINDOW_RESET = STAMP_W'(4000);

  // Configuration port
  localparam int PADDR_W    = 3;
  localparam logic REG_WINDOW = 1'b0;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOSS  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEND  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [LOST_W-1:0]  value;
  } loss_entry_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [BYTES_W-1:0] bytes;
    logic [PING_W-1:0]  ping;
  } send_entry_t;

endpackage

// ===== rtl/core/swlq_ring_ram.sv =====
// ----------------------------------------------------------------------------
// swlq_ring_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swlq_ring_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/swlq_divider.sv =====
// ----------------------------------------------------------------------------
// swlq_divider
// Restoring divider, one quotient bit per cycle, shared by all three means.
// ----------------------------------------------------------------------------
module swlq_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [swlq_pkg::DIV_N_W-1:0] dividend,
  input  logic [swlq_pkg::DIV_D_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic [swlq_pkg::DIV_N_W-1:0] quotient
);
  import swlq_pkg::*;

  logic [DIV_D_W:0]   rem;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_CW-1:0]  cnt;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;

  // Shift in the next dividend bit and try a subtraction
  assign trial = {rem[DIV_D_W-1:0], quotient[DIV_N_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= DIV_CW'(DIV_N_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= diff;
          quotient <= {quotient[DIV_N_W-2:0], 1'b1};
        end else begin
          rem      <= trial;
          quotient <= {quotient[DIV_N_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sliding_window_link_quality_meter_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_link_quality_meter_core
// Windowed loss, byte rate and latency meter built around two sample rings.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a request (loss sample, send sample, clear), a ms
//   timestamp and the sample values; a word is taken when in_valid is high
//   and in_stall low. Every word gives exactly one output word with the
//   current lost rate, byte rate, mean latency and last send time.
//   The window length is written over the APB port at address 0.
// Processing:
//   One word is processed at a time. A loss sample walks the expired loss
//   ring entries and then runs the bit-serial divider for the Q16 mean; a send
//   sample does the same, then walks the expired send entries and runs up to
//   two more divider passes (byte rate, latency). The shared divider and the
//   single read port of each ring set the cost of each word.
// Reset and stall:
//   Synchronous reset empties both rings, zeroes totals and held results
//   and loads a window of 4000 ms. The ring memories need no clearing.
//   A finished result waits in the output register while out_stall is high;
//   the next word is still taken and processed, then waits with in_stall high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_link_quality_meter_core (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swlq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [swlq_pkg::REQ_W-1:0]   req_type,
  input  logic [swlq_pkg::STAMP_W-1:0] now_ms,
  input  logic [swlq_pkg::BYTES_W-1:0] byte_count,
  input  logic [swlq_pkg::PING_W-1:0]  ping_ms,
  input  logic [swlq_pkg::LOST_W-1:0]  lost_fraction,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [swlq_pkg::LOST_W-1:0]  lost_rate,
  output logic [swlq_pkg::RATE_W-1:0]  byte_rate,
  output logic [swlq_pkg::PING_W-1:0]  latency_avg_ms,
  output logic [swlq_pkg::STAMP_W-1:0] last_send_ms
);
  import swlq_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_L_RD  = 4'd1;
  localparam logic [3:0] ST_L_CHK = 4'd2;
  localparam logic [3:0] ST_L_ADD = 4'd3;
  localparam logic [3:0] ST_L_DIV = 4'd4;
  localparam logic [3:0] ST_L_WT  = 4'd5;
  localparam logic [3:0] ST_S_RD  = 4'd6;
  localparam logic [3:0] ST_S_CHK = 4'd7;
  localparam logic [3:0] ST_S_ADD = 4'd8;
  localparam logic [3:0] ST_S_ORD = 4'd9;
  localparam logic [3:0] ST_S_AGE = 4'd10;
  localparam logic [3:0] ST_R_DIV = 4'd11;
  localparam logic [3:0] ST_R_WT  = 4'd12;
  localparam logic [3:0] ST_P_DIV = 4'd13;
  localparam logic [3:0] ST_P_WT  = 4'd14;
  localparam logic [3:0] ST_DONE  = 4'd15;

  logic [3:0] state;

  // Configuration
  logic [STAMP_W-1:0] window;

  // Latched input word
  logic [REQ_W-1:0]   req;
  logic [STAMP_W-1:0] now;
  logic [BYTES_W-1:0] bytes;
  logic [PING_W-1:0]  ping;
  logic [LOST_W-1:0]  lost;

  // Ring bookkeeping and totals
  logic [LOSS_AW-1:0]     loss_ptr;
  logic [LOSS_CW-1:0]     loss_cnt;
  logic [LOSS_TOT_W-1:0]  loss_total;
  logic [SEND_AW-1:0]     send_ptr;
  logic [SEND_CW-1:0]     send_cnt;
  logic [BYTES_TOT_W-1:0] bytes_total;
  logic [PING_TOT_W-1:0]  ping_total;
  logic [SEND_CW-1:0]     ping_samples;

  // Held results
  logic [LOST_W-1:0]  held_lost;
  logic [RATE_W-1:0]  held_rate;
  logic [PING_W-1:0]  held_lat;
  logic [STAMP_W-1:0] held_last;

  // Byte rate operands
  logic [STAMP_W-1:0] age;
  logic [PROD_W-1:0]  prod;

  // Ring memories
  loss_entry_t        loss_q;
  loss_entry_t        loss_wd;
  send_entry_t        send_q;
  send_entry_t        send_wd;
  logic [LOSS_AW-1:0] loss_wa;
  logic [SEND_AW-1:0] send_wa;
  logic [LOSS_CW:0]   loss_sum;
  logic [SEND_CW:0]   send_sum;
  logic               loss_we;
  logic               send_we;
  logic               loss_exp;
  logic               send_exp;

  // Divider
  logic               div_start;
  logic [DIV_N_W-1:0] div_a;
  logic [DIV_D_W-1:0] div_b;
  logic               div_busy;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;

  logic               out_free;

  // APB access
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_WINDOW) ? window : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_WINDOW) begin
      window <= pwdata;
    end
  end

  // Write slots: oldest pointer plus live count, wrapped
  assign loss_sum = (LOSS_CW + 1)'(loss_ptr) + (LOSS_CW + 1)'(loss_cnt);
  assign send_sum = (SEND_CW + 1)'(send_ptr) + (SEND_CW + 1)'(send_cnt);
  assign loss_wa  = (loss_sum >= (LOSS_CW + 1)'(LOSS_DEPTH))
                    ? LOSS_AW'(loss_sum - (LOSS_CW + 1)'(LOSS_DEPTH)) : LOSS_AW'(loss_sum);
  assign send_wa  = (send_sum >= (SEND_CW + 1)'(SEND_DEPTH))
                    ? SEND_AW'(send_sum - (SEND_CW + 1)'(SEND_DEPTH)) : SEND_AW'(send_sum);

  assign loss_we = (state == ST_L_ADD);
  assign send_we = (state == ST_S_ADD);
  assign loss_wd = '{stamp: now, value: lost};
  assign send_wd = '{stamp: now, bytes: bytes, ping: ping};

  // Oldest entry has outlived the window
  assign loss_exp = (now - loss_q.stamp) > window;
  assign send_exp = (now - send_q.stamp) > window;

  swlq_ring_ram #(.WIDTH($bits(loss_entry_t)), .DEPTH(LOSS_DEPTH)) u_loss_ram (
    .clk   (clk),
    .we    (loss_we),
    .waddr (loss_wa),
    .wdata (loss_wd),
    .raddr (loss_ptr),
    .rdata (loss_q)
  );

  swlq_ring_ram #(.WIDTH($bits(send_entry_t)), .DEPTH(SEND_DEPTH)) u_send_ram (
    .clk   (clk),
    .we    (send_we),
    .waddr (send_wa),
    .wdata (send_wd),
    .raddr (send_ptr),
    .rdata (send_q)
  );

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_a     = DIV_N_W'(loss_total);
    div_b     = DIV_D_W'(loss_cnt);
    case (state)
      ST_L_DIV: begin
        div_start = 1'b1;
      end
      ST_R_DIV: begin
        div_start = (age != '0);
        div_a     = DIV_N_W'(prod);
        div_b     = age;
      end
      ST_P_DIV: begin
        div_start = (ping != '0);
        div_a     = DIV_N_W'(ping_total);
        div_b     = DIV_D_W'(ping_samples);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  swlq_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      loss_ptr     <= '0;
      loss_cnt     <= '0;
      loss_total   <= '0;
      send_ptr     <= '0;
      send_cnt     <= '0;
      bytes_total  <= '0;
      ping_total   <= '0;
      ping_samples <= '0;
      held_lost    <= '0;
      held_rate    <= '0;
      held_lat     <= '0;
      held_last    <= '0;
    end else begin
      // output word: load a new one or retire the accepted one
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req   <= req_type;
            now   <= now_ms;
            bytes <= byte_count;
            ping  <= ping_ms;
            lost  <= (lost_fraction > Q16_ONE) ? Q16_ONE : lost_fraction;
            if (req_type == REQ_LOSS || req_type == REQ_SEND) begin
              state <= ST_L_RD;
            end else begin
              state <= ST_DONE;
            end
            if (req_type == REQ_CLEAR) begin
              loss_ptr     <= '0;
              loss_cnt     <= '0;
              loss_total   <= '0;
              send_ptr     <= '0;
              send_cnt     <= '0;
              bytes_total  <= '0;
              ping_total   <= '0;
              ping_samples <= '0;
              held_lost    <= '0;
              held_rate    <= '0;
              held_lat     <= '0;
              held_last    <= '0;
            end
          end
        end
        // loss ring: expire from the oldest end, then evict if full
        ST_L_RD: begin
          state <= (loss_cnt == '0) ? ST_L_ADD : ST_L_CHK;
        end
        ST_L_CHK: begin
          if (loss_exp || loss_cnt == LOSS_CW'(LOSS_DEPTH)) begin
            loss_total <= loss_total - LOSS_TOT_W'(loss_q.value);
            loss_ptr   <= (loss_ptr == LOSS_AW'(LOSS_DEPTH - 1)) ? '0 : loss_ptr + 1'b1;
            loss_cnt   <= loss_cnt - 1'b1;
            state      <= loss_exp ? ST_L_RD : ST_L_ADD;
          end else begin
            state <= ST_L_ADD;
          end
        end
        ST_L_ADD: begin
          loss_cnt   <= loss_cnt + 1'b1;
          loss_total <= loss_total + LOSS_TOT_W'(lost);
          state      <= ST_L_DIV;
        end
        ST_L_DIV: begin
          state <= ST_L_WT;
        end
        ST_L_WT: begin
          if (div_done) begin
            held_lost <= div_q[LOST_W-1:0];
            state     <= (req == REQ_SEND) ? ST_S_RD : ST_DONE;
          end
        end
        // send ring
        ST_S_RD: begin
          state <= (send_cnt == '0) ? ST_S_ADD : ST_S_CHK;
        end
        ST_S_CHK: begin
          if (send_exp || send_cnt == SEND_CW'(SEND_DEPTH)) begin
            bytes_total <= bytes_total - BYTES_TOT_W'(send_q.bytes);
            if (send_q.ping != '0) begin
              ping_total   <= ping_total - PING_TOT_W'(send_q.ping);
              ping_samples <= ping_samples - 1'b1;
            end
            send_ptr <= (send_ptr == SEND_AW'(SEND_DEPTH - 1)) ? '0 : send_ptr + 1'b1;
            send_cnt <= send_cnt - 1'b1;
            state    <= send_exp ? ST_S_RD : ST_S_ADD;
          end else begin
            state <= ST_S_ADD;
          end
        end
        ST_S_ADD: begin
          send_cnt    <= send_cnt + 1'b1;
          bytes_total <= bytes_total + BYTES_TOT_W'(bytes);
          if (ping != '0) begin
            ping_total   <= ping_total + PING_TOT_W'(ping);
            ping_samples <= ping_samples + 1'b1;
          end
          if (bytes != '0) begin
            held_last <= now;
          end
          state <= ST_S_ORD;
        end
        // wait for the oldest send entry to be read back
        ST_S_ORD: begin
          state <= ST_S_AGE;
        end
        ST_S_AGE: begin
          age   <= now - send_q.stamp;
          prod  <= PROD_W'(bytes_total) * PROD_W'(MS_PER_S);
          state <= ST_R_DIV;
        end
        ST_R_DIV: begin
          if (age == '0) begin
            if ((RATE_W + BYTES_TOT_W)'(bytes_total) >> RATE_W != '0) begin
              held_rate <= '1;
            end else begin
              held_rate <= RATE_W'(bytes_total);
            end
            state <= ST_P_DIV;
          end else begin
            state <= ST_R_WT;
          end
        end
        ST_R_WT: begin
          if (div_done) begin
            if ((div_q >> RATE_W) != '0) begin
              held_rate <= '1;
            end else begin
              held_rate <= RATE_W'(div_q);
            end
            state <= ST_P_DIV;
          end
        end
        ST_P_DIV: begin
          state <= (ping != '0) ? ST_P_WT : ST_DONE;
        end
        ST_P_WT: begin
          if (div_done) begin
            held_lat <= div_q[PING_W-1:0];
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            lost_rate      <= held_lost;
            byte_rate      <= held_rate;
            latency_avg_ms <= held_lat;
            last_send_ms   <= held_last;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_CLK(a_loss_cnt_max, loss_cnt <= LOSS_CW'(LOSS_DEPTH), "loss ring overfilled")
  `ASSERT_CLK(a_ping_le_send, ping_samples <= send_cnt, "more pings than send samples")
  `ASSERT_IMPL(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window link quality meter core.
// Words carrying loss samples, send samples, clears and the unused request
// code are driven over the valid/stall input channel. A scoreboard keeps its
// own window model and compares each output word field by field. The window
// length is written over APB between phases. The phases cycle through four mixes of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import swlq_pkg::*;

  typedef struct {
    logic [LOST_W-1:0]  lost;
    logic [RATE_W-1:0]  rate;
    logic [PING_W-1:0]  lat;
    logic [STAMP_W-1:0] last;
  } meter_word_t;

  // Window model of the meter and the queue of words it predicts
  class meter_scoreboard;
    logic [STAMP_W-1:0] window_ms;
    logic [STAMP_W-1:0] loss_stamp [LOSS_DEPTH];
    logic [LOST_W-1:0]  loss_val [LOSS_DEPTH];
    logic [STAMP_W-1:0] send_stamp [SEND_DEPTH];
    logic [BYTES_W-1:0] send_bytes [SEND_DEPTH];
    logic [PING_W-1:0]  send_ping [SEND_DEPTH];
    int unsigned loss_head, loss_cnt, send_head, send_cnt, ping_cnt;
    logic [63:0] loss_sum, byte_sum, ping_sum;
    meter_word_t held;
    meter_word_t pending [$];
    int errors;
    int checked;

    function void clear_all();
      loss_head = 0; loss_cnt = 0; send_head = 0; send_cnt = 0; ping_cnt = 0;
      loss_sum = 0; byte_sum = 0; ping_sum = 0;
      held = '{0, 0, 0, 0};
    endfunction

    function void drop_loss();
      loss_sum -= loss_val[loss_head];
      loss_head = (loss_head + 1) % LOSS_DEPTH;
      loss_cnt--;
    endfunction

    function void drop_send();
      byte_sum -= send_bytes[send_head];
      if (send_ping[send_head] != 0) begin
        ping_sum -= send_ping[send_head];
        ping_cnt--;
      end
      send_head = (send_head + 1) % SEND_DEPTH;
      send_cnt--;
    endfunction

    function void add_loss(logic [STAMP_W-1:0] now, logic [LOST_W-1:0] lost);
      logic [STAMP_W-1:0] age;
      int unsigned wr;
      age = now - loss_stamp[loss_head];
      while (loss_cnt > 0 && age > window_ms) begin
        drop_loss();
        age = now - loss_stamp[loss_head];
      end
      if (loss_cnt >= LOSS_DEPTH) drop_loss();
      if (lost > Q16_ONE) lost = Q16_ONE;
      wr = (loss_head + loss_cnt) % LOSS_DEPTH;
      loss_stamp[wr] = now;
      loss_val[wr] = lost;
      loss_cnt++;
      loss_sum += lost;
      held.lost = LOST_W'(loss_sum / loss_cnt);
    endfunction

    function void add_send(logic [STAMP_W-1:0] now, logic [BYTES_W-1:0] bytes,
                           logic [PING_W-1:0] ping);
      logic [STAMP_W-1:0] age;
      logic [63:0] r;
      int unsigned wr;
      age = now - send_stamp[send_head];
      while (send_cnt > 0 && age > window_ms) begin
        drop_send();
        age = now - send_stamp[send_head];
      end
      if (send_cnt >= SEND_DEPTH) drop_send();
      wr = (send_head + send_cnt) % SEND_DEPTH;
      send_stamp[wr] = now;
      send_bytes[wr] = bytes;
      send_ping[wr] = ping;
      send_cnt++;
      byte_sum += bytes;
      age = now - send_stamp[send_head];
      r = (age > 0) ? byte_sum * 1000 / age : byte_sum;
      held.rate = (r > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : r[47:0];
      if (ping != 0) begin
        ping_sum += ping;
        ping_cnt++;
        held.lat = PING_W'(ping_sum / ping_cnt);
      end
      if (bytes != 0) held.last = now;
    endfunction

    function void note_input(logic [REQ_W-1:0] req, logic [STAMP_W-1:0] now,
                             logic [BYTES_W-1:0] bytes, logic [PING_W-1:0] ping,
                             logic [LOST_W-1:0] lost);
      case (req)
        REQ_CLEAR: clear_all();
        REQ_LOSS: add_loss(now, lost);
        REQ_SEND: begin
          add_loss(now, lost);
          add_send(now, bytes, ping);
        end
        default: ;
      endcase
      pending.push_back(held);
    endfunction

    function void check_result(meter_word_t got);
      meter_word_t exp;
      checked++;
      if (pending.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
        return;
      end
      exp = pending[0];
      pending.delete(0);
      if (got.lost !== exp.lost) begin
        $error("lost_rate: expected %0d, got %0d", exp.lost, got.lost); errors++;
      end
      if (got.rate !== exp.rate) begin
        $error("byte_rate: expected %0d, got %0d", exp.rate, got.rate); errors++;
      end
      if (got.lat !== exp.lat) begin
        $error("latency_avg_ms: expected %0d, got %0d", exp.lat, got.lat); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_send_ms: expected %0d, got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [REQ_W-1:0] req_type;
  logic [STAMP_W-1:0] now_ms;
  logic [BYTES_W-1:0] byte_count;
  logic [PING_W-1:0] ping_ms;
  logic [LOST_W-1:0] lost_fraction;
  logic out_valid, out_stall;
  logic [LOST_W-1:0] lost_rate;
  logic [RATE_W-1:0] byte_rate;
  logic [PING_W-1:0] latency_avg_ms;
  logic [STAMP_W-1:0] last_send_ms;

  sliding_window_link_quality_meter_core dut (.*);

  meter_scoreboard meter_sb;
  int unsigned gap_pct, stall_pct;
  int unsigned words_sent, cycle_count, clears_sent, windows_set;
  logic [STAMP_W-1:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: check accepted words, stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        meter_sb.check_result('{lost_rate, byte_rate, latency_avg_ms, last_send_ms});
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_word(logic [REQ_W-1:0] req, logic [STAMP_W-1:0] now,
                           logic [BYTES_W-1:0] bytes, logic [PING_W-1:0] ping,
                           logic [LOST_W-1:0] lost);
    req_type <= req; now_ms <= now; byte_count <= bytes;
    ping_ms <= ping; lost_fraction <= lost; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    meter_sb.note_input(req, now, bytes, ping, lost);
    words_sent++;
    if (req == REQ_CLEAR) clears_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // APB write of the window, then read it back
  task automatic set_window(logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_WINDOW) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      $error("sample_window_ms: expected %0d, got %0d", value, prdata);
      meter_sb.errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    meter_sb.window_ms = value;
    windows_set++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (meter_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_word();
    logic [REQ_W-1:0] req;
    logic [BYTES_W-1:0] bytes;
    logic [PING_W-1:0] ping;
    logic [LOST_W-1:0] lost;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) req = REQ_LOSS;
    else if (pick < 92) req = REQ_SEND;
    else if (pick < 96) req = REQ_CLEAR;
    else req = REQ_NONE;
    // mostly small steps so the rings fill, sometimes long jumps
    pick = $urandom_range(0, 99);
    if (pick < 70) clock_ms += $urandom_range(0, 150);
    else if (pick < 92) clock_ms += $urandom_range(0, 6000);
    else clock_ms = $urandom;
    bytes = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF :
            ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20000));
    pick = $urandom_range(0, 9);
    ping = (pick < 3) ? '0 : (pick == 3) ? 16'hFFFF : 16'($urandom);
    lost = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    send_word(req, clock_ms, bytes, ping, lost);
  endtask

  logic [31:0] windows [6] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd50, 32'd700, 32'd4000};

  initial begin
    meter_sb = new();
    meter_sb.clear_all();
    meter_sb.window_ms = WINDOW_RESET;
    gap_pct = 0; stall_pct = 0; words_sent = 0; cycle_count = 0;
    clears_sent = 0; windows_set = 0; clock_ms = 32'hFFFF_F000;
    rst <= 1'b1; psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= '0; pwdata <= '0; in_valid <= 1'b0; out_stall <= 1'b0;
    req_type <= REQ_LOSS; now_ms <= '0; byte_count <= '0; ping_ms <= '0;
    lost_fraction <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset window
    send_word(REQ_LOSS, 32'h0, 32'h0, 16'h0, 17'd0);
    send_word(REQ_LOSS, 32'h0, 32'h0, 16'h0, 17'd65536);
    send_word(REQ_LOSS, 32'd10, 32'h0, 16'h0, 17'h1FFFF);
    send_word(REQ_SEND, 32'd10, 32'hFFFF_FFFF, 16'hFFFF, 17'd1);
    send_word(REQ_SEND, 32'd10, 32'hFFFF_FFFF, 16'h0, 17'd0);
    send_word(REQ_SEND, 32'd20, 32'd0, 16'd1, 17'd32768);
    send_word(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h1FFFF);
    send_word(REQ_SEND, 32'd4020, 32'd1000, 16'd0, 17'd0);   // older entries expire, the stamp-20 entries stay
    send_word(REQ_SEND, 32'd4021, 32'd1000, 16'd0, 17'd0);   // ping samples age out, latency held
    send_word(REQ_SEND, 32'd4022, 32'd500, 16'd7, 17'd100);
    send_word(REQ_CLEAR, 32'd0, 32'd0, 16'd0, 17'd0);
    send_word(REQ_SEND, 32'hFFFF_FFF0, 32'd123, 16'd40, 17'd600);
    send_word(REQ_SEND, 32'h0000_0010, 32'd456, 16'd60, 17'd700); // time wraps
    for (int i = 0; i < 70; i++)                             // overfill both rings
      send_word(REQ_SEND, 32'h20 + i, 32'hFFFF_FFFF - i, 16'(i), 17'(i * 900));
    send_word(REQ_CLEAR, 32'd5, 32'd1, 16'd1, 17'd1);
    drain();

    // Random phases, cycling through windows and idling mixes
    for (int p = 0; p < 12; p++) begin
      set_window(windows[p % 6]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 72; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 72; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      for (int i = 0; i < 80; i++) random_word();
      drain();
    end
    stall_pct = 0;
    repeat (500) @(posedge clk);

    if (meter_sb.pending.size() != 0) begin
      $error("%0d expected words never arrived", meter_sb.pending.size());
      meter_sb.errors++;
    end
    $display("%0d words sent (%0d clears), %0d results checked, %0d window settings",
             words_sent, clears_sent, meter_sb.checked, windows_set);
    if (meter_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
